// ----- design/bcr_pkg.sv -----
// Shared types, codes and constants of the bootloader command receiver.
package bcr_pkg;

    // Largest byte count that a program command may announce.
    localparam int DATA_SIZE = 128;

    // Configuration port address width and register indexes.
    localparam int          ADDR_W       = 3;
    localparam logic [0:0]  REG_PASSWORD = 1'b0;

    // Bus event codes.
    typedef enum logic [1:0] {
        OP_ADDR  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_DONE  = 2'd3
    } op_t;

    // Receive phase of the write side.
    typedef enum logic [1:0] {
        PH_CMD  = 2'd0,
        PH_ARG  = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    // Command bytes.
    localparam logic [7:0] CMD_INFO    = 8'hC0;
    localparam logic [7:0] CMD_UNLOCK  = 8'hC1;
    localparam logic [7:0] CMD_PROGRAM = 8'hC2;
    localparam logic [7:0] CMD_RESET   = 8'hC4;
    localparam logic [7:0] CMD_STATUS  = 8'hC5;

    // Action request codes.
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_INFO    = 3'd1;
    localparam logic [2:0] ACT_UNLOCK  = 3'd2;
    localparam logic [2:0] ACT_CLRLEN  = 3'd3;
    localparam logic [2:0] ACT_PROGRAM = 3'd4;
    localparam logic [2:0] ACT_RESET   = 3'd5;

    // Status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_CMD  = 3'd1;
    localparam logic [2:0] ST_BAD_LEN  = 3'd2;
    localparam logic [2:0] ST_BAD_ARG  = 3'd3;
    localparam logic [2:0] ST_EXEC_ERR = 3'd4;

    // Read-side selections.
    localparam logic [1:0] RS_NONE   = 2'd0;
    localparam logic [1:0] RS_STATUS = 2'd1;
    localparam logic [1:0] RS_INFO   = 2'd2;
    localparam logic [1:0] RS_WAIT   = 2'd3;

    // One result item.
    typedef struct packed {
        logic        ack;
        logic [1:0]  read_select;
        logic [2:0]  status_byte;
        logic [7:0]  info_index;
        logic        data_write;
        logic [7:0]  data_index;
        logic [2:0]  action;
        logic [31:0] action_arg;
    } result_t;

endpackage

// ----- design/bcr_core.sv -----
// Receiver state and the per-event decision logic of the bootloader receiver.
module bcr_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [1:0]         op,
    input  logic               dir_read,
    input  logic [7:0]         data_byte,
    input  logic               host_acked,
    input  logic               action_ok,
    input  logic [31:0]        password,
    output bcr_pkg::result_t   result
);

    bcr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      cmd_reg, cmd_next;
    logic [1:0]      bpos_reg, bpos_next;
    logic [1:0]      words_reg, words_next;
    logic [31:0]     arg_reg [2];
    logic [31:0]     arg_next [2];
    logic [31:0]     arg_new [2];
    logic [7:0]      dcount_reg, dcount_next;
    logic [2:0]      status_reg, status_next;
    logic            info_sel_reg, info_sel_next;
    logic            first_read_reg, first_read_next;
    logic            reading_reg, reading_next;
    logic [2:0]      pending_reg, pending_next;
    logic [7:0]      info_ptr_reg, info_ptr_next;
    logic [1:0]      words_inc;
    logic [7:0]      dcount_inc;

    // Decision logic for one event.
    always_comb begin
        phase_next      = phase_reg;
        cmd_next        = cmd_reg;
        bpos_next       = bpos_reg;
        words_next      = words_reg;
        arg_next        = arg_reg;
        dcount_next     = dcount_reg;
        status_next     = status_reg;
        info_sel_next   = info_sel_reg;
        first_read_next = first_read_reg;
        reading_next    = reading_reg;
        pending_next    = pending_reg;
        info_ptr_next   = info_ptr_reg;
        result          = '0;

        // Argument word with the incoming byte placed at the current position.
        arg_new = arg_reg;
        arg_new[words_reg[0]][{bpos_reg, 3'b000} +: 8] = data_byte;
        words_inc  = words_reg + 2'd1;
        dcount_inc = dcount_reg + 8'd1;

        unique case (bcr_pkg::op_t'(op))
            bcr_pkg::OP_ADDR: begin
                first_read_next = 1'b1;
                reading_next    = dir_read;
                phase_next      = bcr_pkg::PH_CMD;
                result.ack      = 1'b1;
            end
            bcr_pkg::OP_WRITE: begin
                if (!reading_reg) begin
                    unique case (phase_reg)
                        bcr_pkg::PH_ARG: begin
                            arg_next = arg_new;
                            if (bpos_reg != 2'd0) begin
                                bpos_next  = bpos_reg - 2'd1;
                                result.ack = 1'b1;
                            end else begin
                                words_next = words_inc;
                                if (cmd_reg == bcr_pkg::CMD_UNLOCK && words_inc < 2'd2) begin
                                    bpos_next  = 2'd3;
                                    result.ack = 1'b1;
                                end else begin
                                    // Last argument byte: act on the command.
                                    phase_next = bcr_pkg::PH_CMD;
                                    if (cmd_reg == bcr_pkg::CMD_UNLOCK) begin
                                        if (arg_new[0] == password) begin
                                            result.action     = bcr_pkg::ACT_UNLOCK;
                                            result.action_arg = arg_new[1];
                                            pending_next      = bcr_pkg::ACT_UNLOCK;
                                            result.ack        = 1'b1;
                                        end else begin
                                            result.action = bcr_pkg::ACT_CLRLEN;
                                            status_next   = bcr_pkg::ST_BAD_ARG;
                                        end
                                    end else if (cmd_reg == bcr_pkg::CMD_PROGRAM) begin
                                        if (arg_new[0] > 32'(bcr_pkg::DATA_SIZE)) begin
                                            status_next = bcr_pkg::ST_BAD_LEN;
                                        end else begin
                                            dcount_next = 8'd0;
                                            phase_next  = bcr_pkg::PH_DATA;
                                            result.ack  = 1'b1;
                                        end
                                    end else if (cmd_reg == bcr_pkg::CMD_RESET) begin
                                        if (arg_new[0] == password) begin
                                            result.action = bcr_pkg::ACT_RESET;
                                            pending_next  = bcr_pkg::ACT_RESET;
                                            result.ack    = 1'b1;
                                        end else begin
                                            status_next = bcr_pkg::ST_BAD_ARG;
                                        end
                                    end else begin
                                        result.ack = 1'b1;
                                    end
                                end
                            end
                        end
                        bcr_pkg::PH_DATA: begin
                            result.ack        = 1'b1;
                            result.data_write = 1'b1;
                            result.data_index = dcount_reg;
                            dcount_next       = dcount_inc;
                            if ({24'd0, dcount_inc} >= arg_reg[0]) begin
                                phase_next        = bcr_pkg::PH_CMD;
                                result.action     = bcr_pkg::ACT_PROGRAM;
                                result.action_arg = {24'd0, dcount_inc};
                                pending_next      = bcr_pkg::ACT_PROGRAM;
                            end
                        end
                        default: begin
                            // Command byte; the unused phase code lands here too.
                            cmd_next   = data_byte;
                            bpos_next  = 2'd3;
                            words_next = 2'd0;
                            if (data_byte < bcr_pkg::CMD_INFO || data_byte > bcr_pkg::CMD_STATUS) begin
                                status_next = bcr_pkg::ST_BAD_CMD;
                            end else begin
                                result.ack = 1'b1;
                                if (data_byte == bcr_pkg::CMD_INFO) begin
                                    result.action = bcr_pkg::ACT_INFO;
                                    pending_next  = bcr_pkg::ACT_INFO;
                                    info_sel_next = 1'b1;
                                end else if (data_byte == bcr_pkg::CMD_STATUS) begin
                                    info_sel_next = 1'b0;
                                end else begin
                                    phase_next = bcr_pkg::PH_ARG;
                                end
                            end
                        end
                    endcase
                end
            end
            bcr_pkg::OP_READ: begin
                if (reading_reg && first_read_reg && host_acked) begin
                    result.read_select = bcr_pkg::RS_STATUS;
                    result.status_byte = status_reg;
                    status_next        = bcr_pkg::ST_OK;
                    first_read_next    = 1'b0;
                end else if (reading_reg && !first_read_reg && info_sel_reg && host_acked) begin
                    result.read_select = bcr_pkg::RS_INFO;
                    result.info_index  = info_ptr_reg;
                    info_ptr_next      = info_ptr_reg + 8'd1;
                end else begin
                    result.read_select = bcr_pkg::RS_WAIT;
                end
            end
            bcr_pkg::OP_DONE: begin
                if (pending_reg != bcr_pkg::ACT_NONE && pending_reg != bcr_pkg::ACT_RESET) begin
                    status_next = action_ok ? bcr_pkg::ST_OK : bcr_pkg::ST_EXEC_ERR;
                    if (pending_reg == bcr_pkg::ACT_INFO) begin
                        info_ptr_next = 8'd0;
                    end
                    pending_next = bcr_pkg::ACT_NONE;
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

    // State registers, updated when an item is accepted.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= bcr_pkg::PH_CMD;
            cmd_reg        <= 8'd0;
            bpos_reg       <= 2'd3;
            words_reg      <= 2'd0;
            arg_reg[0]     <= 32'd0;
            arg_reg[1]     <= 32'd0;
            dcount_reg     <= 8'd0;
            status_reg     <= bcr_pkg::ST_OK;
            info_sel_reg   <= 1'b0;
            first_read_reg <= 1'b0;
            reading_reg    <= 1'b0;
            pending_reg    <= bcr_pkg::ACT_NONE;
            info_ptr_reg   <= 8'd0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            cmd_reg        <= cmd_next;
            bpos_reg       <= bpos_next;
            words_reg      <= words_next;
            arg_reg[0]     <= arg_next[0];
            arg_reg[1]     <= arg_next[1];
            dcount_reg     <= dcount_next;
            status_reg     <= status_next;
            info_sel_reg   <= info_sel_next;
            first_read_reg <= first_read_next;
            reading_reg    <= reading_next;
            pending_reg    <= pending_next;
            info_ptr_reg   <= info_ptr_next;
        end
    end

endmodule

// ----- design/bootloader_command_receiver.sv -----
// Top level of the bootloader command receiver: handshake, result register, register port.
// A result is registered and is valid in the cycle after its bus event item is accepted.
// Throughput: one item per cycle; the decision logic sits between the input ports
// and the result register, and while a result waits a new item is taken only in the
// cycle in which that result is accepted.
// Reset (aresetn low, synchronous): receiver state, password and result valid are
// cleared, and no item is accepted while reset is held.
module bootloader_command_receiver (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Bus event items.
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_op,
    input  logic                       s_dir_read,
    input  logic [7:0]                 s_data_byte,
    input  logic                       s_host_acked,
    input  logic                       s_action_ok,
    // Result items.
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_ack,
    output logic [1:0]                 m_read_select,
    output logic [2:0]                 m_status_byte,
    output logic [7:0]                 m_info_index,
    output logic                       m_data_write,
    output logic [7:0]                 m_data_index,
    output logic [2:0]                 m_action,
    output logic [31:0]                m_action_arg,
    // Configuration port.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bcr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic             accept;
    logic             cfg_write;
    logic             m_valid_reg;
    logic [31:0]      password_reg;
    bcr_pkg::result_t result;
    bcr_pkg::result_t result_reg;

    // Accept whenever the result register is empty or being emptied.
    assign s_ready = aresetn && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    bcr_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .op         (s_op),
        .dir_read   (s_dir_read),
        .data_byte  (s_data_byte),
        .host_acked (s_host_acked),
        .action_ok  (s_action_ok),
        .password   (password_reg),
        .result     (result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_ack         = result_reg.ack;
    assign m_read_select = result_reg.read_select;
    assign m_status_byte = result_reg.status_byte;
    assign m_info_index  = result_reg.info_index;
    assign m_data_write  = result_reg.data_write;
    assign m_data_index  = result_reg.data_index;
    assign m_action      = result_reg.action;
    assign m_action_arg  = result_reg.action_arg;

    // Password register, written in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            password_reg <= 32'd0;
        end else if (cfg_write && paddr[2] == bcr_pkg::REG_PASSWORD) begin
            password_reg <= pwdata;
        end
    end

    assign prdata = (paddr[2] == bcr_pkg::REG_PASSWORD) ? password_reg : 32'd0;

endmodule

// ----- design/bcr_checker.sv -----
// Port-level checks of the bootloader command receiver and their binding.
module bcr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_read_select,
    input logic [2:0]  m_status_byte,
    input logic        m_data_write,
    input logic [7:0]  m_data_index,
    input logic [2:0]  m_action,
    input logic [31:0] m_action_arg
);

    // A stalled result item stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped while stalled");

    // Every accepted item yields a result in the next cycle.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted item produced no result");

    // A status byte is only carried with the status selection.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_read_select != bcr_pkg::RS_STATUS |-> m_status_byte == bcr_pkg::ST_OK)
        else $error("status byte without status selection");

    // A data index is only carried with a write strobe.
    a_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data_write |-> m_data_index == 8'd0)
        else $error("data index without write strobe");

    // Only unlock and program requests carry an argument.
    a_arg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action_arg != 32'd0 |->
            m_action == bcr_pkg::ACT_UNLOCK || m_action == bcr_pkg::ACT_PROGRAM)
        else $error("action argument on wrong action");

endmodule

bind bootloader_command_receiver bcr_checker u_bcr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_read_select (m_read_select),
    .m_status_byte (m_status_byte),
    .m_data_write  (m_data_write),
    .m_data_index  (m_data_index),
    .m_action      (m_action),
    .m_action_arg  (m_action_arg)
);

// ----- tb/bcr_result_checker.sv -----
// Result checker of the bootloader command receiver: predicts each result item and compares it.
module bcr_result_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [1:0]                 s_op,
    input  logic                       s_dir_read,
    input  logic [7:0]                 s_data_byte,
    input  logic                       s_host_acked,
    input  logic                       s_action_ok,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic                       m_ack,
    input  logic [1:0]                 m_read_select,
    input  logic [2:0]                 m_status_byte,
    input  logic [7:0]                 m_info_index,
    input  logic                       m_data_write,
    input  logic [7:0]                 m_data_index,
    input  logic [2:0]                 m_action,
    input  logic [31:0]                m_action_arg,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bcr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    input  logic                       pready,
    output int                         fail_count,
    output int                         pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    // Mirror of the receiver state.
    logic [31:0]      password_reg;
    bcr_pkg::phase_t  rx_phase;
    logic [7:0]       cmd_byte;
    logic [1:0]       arg_byte_pos;
    logic [1:0]       words_taken;
    logic [31:0]      arg_word [2];
    logic [7:0]       prog_count;
    logic [2:0]       status_reg;
    logic             info_selected;
    logic             status_pending;
    logic             host_is_reading;
    logic [2:0]       queued_action;
    logic [7:0]       info_ptr;

    // Results still owed by the block, oldest first.
    bcr_pkg::result_t expected_q [$];

    function automatic string describe(bcr_pkg::result_t r);
        return $sformatf("ack=%0d sel=%0d status=%0d info=%0d wr=%0d idx=%0d act=%0d arg=%h",
                         r.ack, r.read_select, r.status_byte, r.info_index, r.data_write,
                         r.data_index, r.action, r.action_arg);
    endfunction

    // Works out the result of one bus event and advances the mirrored state.
    function automatic bcr_pkg::result_t predict_response(bcr_pkg::op_t op, logic dir,
                                                          logic [7:0] b, logic acked,
                                                          logic ok);
        bcr_pkg::result_t r;
        int               slot;
        r = '0;
        case (op)
            bcr_pkg::OP_ADDR: begin
                status_pending  = 1'b1;
                host_is_reading = dir;
                rx_phase        = bcr_pkg::PH_CMD;
                r.ack           = 1'b1;
            end
            bcr_pkg::OP_WRITE: begin
                // Written bytes are refused outright while the host reads.
                if (!host_is_reading) begin
                    r.ack = 1'b1;
                    if (rx_phase == bcr_pkg::PH_ARG) begin
                        // Argument words arrive most significant byte first.
                        slot = words_taken[0];
                        arg_word[slot][arg_byte_pos*8 +: 8] = b;
                        if (arg_byte_pos != 2'd0) begin
                            arg_byte_pos = arg_byte_pos - 2'd1;
                        end else begin
                            words_taken = words_taken + 2'd1;
                            if (cmd_byte == bcr_pkg::CMD_UNLOCK && words_taken < 2) begin
                                arg_byte_pos = 2'd3;
                            end else begin
                                // All arguments are in: act on the command.
                                rx_phase = bcr_pkg::PH_CMD;
                                if (cmd_byte == bcr_pkg::CMD_UNLOCK) begin
                                    if (arg_word[0] == password_reg) begin
                                        r.action      = bcr_pkg::ACT_UNLOCK;
                                        r.action_arg  = arg_word[1];
                                        queued_action = bcr_pkg::ACT_UNLOCK;
                                    end else begin
                                        r.action   = bcr_pkg::ACT_CLRLEN;
                                        status_reg = bcr_pkg::ST_BAD_ARG;
                                        r.ack      = 1'b0;
                                    end
                                end else if (cmd_byte == bcr_pkg::CMD_PROGRAM) begin
                                    if (arg_word[0] > 32'(bcr_pkg::DATA_SIZE)) begin
                                        status_reg = bcr_pkg::ST_BAD_LEN;
                                        r.ack      = 1'b0;
                                    end else begin
                                        prog_count = 8'd0;
                                        rx_phase   = bcr_pkg::PH_DATA;
                                    end
                                end else if (cmd_byte == bcr_pkg::CMD_RESET) begin
                                    if (arg_word[0] == password_reg) begin
                                        r.action      = bcr_pkg::ACT_RESET;
                                        queued_action = bcr_pkg::ACT_RESET;
                                    end else begin
                                        status_reg = bcr_pkg::ST_BAD_ARG;
                                        r.ack      = 1'b0;
                                    end
                                end
                            end
                        end
                    end else if (rx_phase == bcr_pkg::PH_DATA) begin
                        // Program data: a zero count still takes one byte.
                        r.data_write = 1'b1;
                        r.data_index = prog_count;
                        prog_count   = prog_count + 8'd1;
                        if ({24'd0, prog_count} >= arg_word[0]) begin
                            rx_phase      = bcr_pkg::PH_CMD;
                            r.action      = bcr_pkg::ACT_PROGRAM;
                            r.action_arg  = {24'd0, prog_count};
                            queued_action = bcr_pkg::ACT_PROGRAM;
                        end
                    end else begin
                        // Command byte; an unused phase code behaves the same way.
                        cmd_byte     = b;
                        arg_byte_pos = 2'd3;
                        words_taken  = 2'd0;
                        if (b < bcr_pkg::CMD_INFO || b > bcr_pkg::CMD_STATUS) begin
                            status_reg = bcr_pkg::ST_BAD_CMD;
                            r.ack      = 1'b0;
                        end else if (b == bcr_pkg::CMD_INFO) begin
                            r.action      = bcr_pkg::ACT_INFO;
                            queued_action = bcr_pkg::ACT_INFO;
                            info_selected = 1'b1;
                        end else if (b == bcr_pkg::CMD_STATUS) begin
                            info_selected = 1'b0;
                        end else begin
                            rx_phase = bcr_pkg::PH_ARG;
                        end
                    end
                end
            end
            bcr_pkg::OP_READ: begin
                // Status goes out first and is cleared, then info bytes if selected.
                if (host_is_reading && status_pending && acked) begin
                    r.read_select  = bcr_pkg::RS_STATUS;
                    r.status_byte  = status_reg;
                    status_reg     = bcr_pkg::ST_OK;
                    status_pending = 1'b0;
                end else if (host_is_reading && !status_pending && info_selected && acked) begin
                    r.read_select = bcr_pkg::RS_INFO;
                    r.info_index  = info_ptr;
                    info_ptr      = info_ptr + 8'd1;
                end else begin
                    r.read_select = bcr_pkg::RS_WAIT;
                end
            end
            default: begin
                // Action done: ignored with nothing pending or after a reset request.
                if (queued_action != bcr_pkg::ACT_NONE && queued_action != bcr_pkg::ACT_RESET) begin
                    status_reg = ok ? bcr_pkg::ST_OK : bcr_pkg::ST_EXEC_ERR;
                    if (queued_action == bcr_pkg::ACT_INFO)
                        info_ptr = 8'd0;
                    queued_action = bcr_pkg::ACT_NONE;
                end
            end
        endcase
        return r;
    endfunction

    // Everything is sampled at the rising edge, so the order of events does not matter.
    always @(posedge aclk) begin : sample_edge
        bcr_pkg::result_t got;
        bcr_pkg::result_t want;
        if (!aresetn) begin
            password_reg    = '0;
            rx_phase        = bcr_pkg::PH_CMD;
            cmd_byte        = '0;
            arg_byte_pos    = 2'd3;
            words_taken     = '0;
            arg_word[0]     = '0;
            arg_word[1]     = '0;
            prog_count      = '0;
            status_reg      = bcr_pkg::ST_OK;
            info_selected   = 1'b0;
            status_pending  = 1'b0;
            host_is_reading = 1'b0;
            queued_action   = bcr_pkg::ACT_NONE;
            info_ptr        = '0;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready &&
                paddr == bcr_pkg::ADDR_W'({bcr_pkg::REG_PASSWORD, 2'b00}))
                password_reg = pwdata;
            if (s_valid && s_ready)
                expected_q.push_back(predict_response(bcr_pkg::op_t'(s_op), s_dir_read,
                                                      s_data_byte, s_host_acked,
                                                      s_action_ok));
            if (m_valid && m_ready) begin
                got = {m_ack, m_read_select, m_status_byte, m_info_index, m_data_write,
                       m_data_index, m_action, m_action_arg};
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result item with none expected: %s", $realtime,
                                 describe(got));
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                                     $realtime, describe(want), describe(got));
                    end
                end
            end
        end
        pending_results = expected_q.size();
    end

endmodule

// ----- tb/bootloader_command_receiver_tb.sv -----
// Testbench top of the bootloader command receiver: clock, reset, stimulus and verdict.
module bootloader_command_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Command byte that takes one word and is otherwise ignored.
    localparam logic [7:0] CMD_SPARE = 8'hC3;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [1:0]                 s_op;
    logic                       s_dir_read;
    logic [7:0]                 s_data_byte;
    logic                       s_host_acked;
    logic                       s_action_ok;
    logic                       m_valid;
    logic                       m_ready;
    logic                       m_ack;
    logic [1:0]                 m_read_select;
    logic [2:0]                 m_status_byte;
    logic [7:0]                 m_info_index;
    logic                       m_data_write;
    logic [7:0]                 m_data_index;
    logic [2:0]                 m_action;
    logic [31:0]                m_action_arg;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [bcr_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    int          fail_count;
    int          pending_results;
    int          items_sent = 0;
    logic        throttle;
    logic [31:0] cur_password;

    bootloader_command_receiver i_dut (.*);

    bcr_result_checker i_checker (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side stalls at random while throttling is on.
    always @(negedge aclk)
        m_ready <= !throttle || ($urandom_range(99) >= 31);

    // Offers one bus event item and holds it until it is accepted.
    task automatic bus_event(bcr_pkg::op_t op, logic dir, logic [7:0] data, logic acked,
                             logic ok);
        while (throttle && $urandom_range(99) < 31) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_dir_read   <= dir;
        s_data_byte  <= data;
        s_host_acked <= acked;
        s_action_ok  <= ok;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // Fields that an event does not use carry random values.
    task automatic host_start(logic dir);
        bus_event(bcr_pkg::OP_ADDR, dir, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
    endtask

    task automatic host_write(logic [7:0] data);
        bus_event(bcr_pkg::OP_WRITE, 1'($urandom_range(1)), data, 1'($urandom_range(1)),
                  1'($urandom_range(1)));
    endtask

    task automatic host_read(logic acked);
        bus_event(bcr_pkg::OP_READ, 1'($urandom_range(1)), 8'($urandom_range(255)), acked,
                  1'($urandom_range(1)));
    endtask

    task automatic action_done(logic ok);
        bus_event(bcr_pkg::OP_DONE, 1'($urandom_range(1)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), ok);
    endtask

    task automatic host_word(logic [31:0] word);
        for (int i = 3; i >= 0; i--)
            host_write(word[8*i +: 8]);
    endtask

    // Stops offering items and waits until every result has come out.
    task automatic quiesce();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_results != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic set_password(logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= bcr_pkg::ADDR_W'({bcr_pkg::REG_PASSWORD, 2'b00});
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_password = value;
    endtask

    // Mostly the right password, sometimes one bit off or anything at all.
    function automatic logic [31:0] pick_key();
        int roll;
        roll = $urandom_range(9);
        if (roll < 6)
            return cur_password;
        if (roll < 8)
            return cur_password ^ (32'd1 << $urandom_range(31));
        return $urandom;
    endfunction

    // One random host transaction, mostly well formed.
    task automatic random_transaction();
        int          pick;
        int          n;
        logic [31:0] count;
        pick = $urandom_range(99);
        if (pick < 12) begin
            host_start(1'b0);
            host_write(bcr_pkg::CMD_INFO);
            if ($urandom_range(99) < 70)
                action_done(1'($urandom_range(1)));
        end else if (pick < 32) begin
            host_start(1'b1);
            n = $urandom_range(8, 1);
            repeat (n) host_read($urandom_range(7) != 0);
        end else if (pick < 46) begin
            host_start(1'b0);
            host_write(bcr_pkg::CMD_UNLOCK);
            host_word(pick_key());
            host_word($urandom);
            if ($urandom_range(99) < 70)
                action_done(1'($urandom_range(1)));
        end else if (pick < 62) begin
            // Program block: small counts mostly, some mid-range, a few full or too long.
            host_start(1'b0);
            host_write(bcr_pkg::CMD_PROGRAM);
            n = $urandom_range(99);
            if (n < 75)
                count = $urandom_range(16);
            else if (n < 84)
                count = bcr_pkg::DATA_SIZE;
            else if (n < 92)
                count = $urandom_range(bcr_pkg::DATA_SIZE - 1, 17);
            else if (n < 96)
                count = bcr_pkg::DATA_SIZE + 1;
            else
                count = $urandom | 32'h8000_0000;
            host_word(count);
            if (count > bcr_pkg::DATA_SIZE)
                n = $urandom_range(2);
            else
                n = (count == 0) ? 1 : int'(count);
            // Now and then the block is cut short.
            if (n > 1 && $urandom_range(7) == 0)
                n = $urandom_range(n - 1);
            repeat (n) host_write(8'($urandom_range(255)));
            if ($urandom_range(99) < 70)
                action_done(1'($urandom_range(1)));
        end else if (pick < 70) begin
            host_start(1'b0);
            host_write(bcr_pkg::CMD_RESET);
            host_word(pick_key());
            if ($urandom_range(1))
                action_done(1'($urandom_range(1)));
        end else if (pick < 76) begin
            host_start(1'b0);
            if ($urandom_range(1)) begin
                host_write(bcr_pkg::CMD_STATUS);
            end else begin
                host_write(CMD_SPARE);
                host_word($urandom);
            end
        end else if (pick < 84) begin
            action_done(1'($urandom_range(1)));
        end else begin
            // Noise: any event with any field values.
            bus_event(bcr_pkg::op_t'($urandom_range(3)), 1'($urandom_range(1)),
                      8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int goal;
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_op         = bcr_pkg::OP_ADDR;
        s_dir_read   = 1'b0;
        s_data_byte  = '0;
        s_host_acked = 1'b0;
        s_action_ok  = 1'b0;
        m_ready      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        throttle     = 1'b1;
        cur_password = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        set_password(32'hFFFF_FFFF);

        // Action done with nothing pending is ignored.
        action_done(1'b1);
        // Bytes outside the command range are refused.
        host_start(1'b0);
        host_write(8'h00);
        host_write(8'hFF);
        // A byte requested during a write transfer only waits.
        host_read(1'b1);
        // Read without acknowledge, status byte, then no info selected.
        host_start(1'b1);
        host_read(1'b0);
        host_read(1'b1);
        host_read(1'b1);
        // A written byte during a read transfer is refused.
        host_write(bcr_pkg::CMD_INFO);
        // Info fetch that fails, then status and the first info bytes.
        host_start(1'b0);
        host_write(bcr_pkg::CMD_INFO);
        action_done(1'b0);
        host_start(1'b1);
        host_read(1'b1);
        host_read(1'b1);
        host_read(1'b1);
        // A zero program count still takes exactly one data byte.
        host_start(1'b0);
        host_write(bcr_pkg::CMD_PROGRAM);
        host_word(32'd0);
        host_write(8'hA5);

        // Long info stream so that the info index wraps.
        host_start(1'b0);
        host_write(bcr_pkg::CMD_INFO);
        action_done(1'b1);
        host_start(1'b1);
        repeat (260) host_read(1'b1);

        // Random phases, each under its own password; the third runs without gaps.
        for (int phase = 0; phase < 4; phase++) begin
            quiesce();
            case (phase)
                0:       set_password(32'h0000_0000);
                3:       set_password(32'hFFFF_FFFF);
                default: set_password($urandom);
            endcase
            throttle = (phase != 2);
            goal = items_sent + 75;
            while (items_sent < goal)
                random_transaction();
        end

        quiesce();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
